// ===== design/lsw_pkg.sv =====
package lsw_pkg;

	localparam int SPLIT_SLOTS_DEF = 16;

	localparam int SEC_W   = 32;
	localparam int CS_W    = 7;
	localparam int IDX_W   = 4;
	localparam int REM_W   = 12;
	localparam int HOURS_W = 21;
	localparam int MS_W    = 6;
	localparam int LAP_W   = 5;

	localparam int CENTI_PER_SEC = 100;
	localparam logic [CS_W-1:0]  CENTI_MAX    = CS_W'(CENTI_PER_SEC - 1);
	localparam logic [SEC_W-1:0] SEC_PER_HOUR = SEC_W'(60 * 60);
	localparam logic [REM_W-1:0] SEC_PER_MIN  = REM_W'(60);

	// hours: (secs >> 4) * ceil(2^36 / 225) >> 36
	localparam int HSHIFT_IN = 4;
	localparam int RH_W      = 29;
	localparam int RH_SHIFT  = 36;
	localparam logic [RH_W-1:0] RECIP_HOUR = RH_W'(305419897);

	// minutes: (rem >> 2) * ceil(2^14 / 15) >> 14
	localparam int MSHIFT_IN = 2;
	localparam int RM_W      = 11;
	localparam int RM_SHIFT  = 14;
	localparam logic [RM_W-1:0] RECIP_MIN = RM_W'(1093);

	typedef enum logic [2:0] {
		REQ_TICK  = 3'd0,
		REQ_START = 3'd1,
		REQ_STOP  = 3'd2,
		REQ_CLEAR = 3'd3,
		REQ_SAVE  = 3'd4,
		REQ_READ  = 3'd5,
		REQ_DIFF  = 3'd6
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RD_A,
		ST_RD_B,
		ST_FORM,
		ST_CONV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic exec;
		logic rd;
		logic rd_second;
		logic cap_a;
		logic cap_b;
		logic form;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic div_last;
		logic out_free;
	} stat_t;

endpackage

// ===== design/lsw_div.sv =====
module lsw_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           load,
	input  logic [lsw_pkg::SEC_W-1:0]      dividend,
	output logic [lsw_pkg::HOURS_W-1:0]    hours,
	output logic [lsw_pkg::MS_W-1:0]       minutes,
	output logic [lsw_pkg::MS_W-1:0]       secs,
	output logic                           last
);

	localparam int HX_W = lsw_pkg::SEC_W - lsw_pkg::HSHIFT_IN;
	localparam int PH_W = HX_W + lsw_pkg::RH_W;
	localparam int MX_W = lsw_pkg::REM_W - lsw_pkg::MSHIFT_IN;
	localparam int PM_W = MX_W + lsw_pkg::RM_W;

	logic                          vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [lsw_pkg::SEC_W-1:0]     sec_s1, sec_s2;
	logic [lsw_pkg::HOURS_W-1:0]   hours_s2, hours_s3, hours_s4, hours_s5;
	logic [lsw_pkg::REM_W-1:0]     rem_s3, rem_s4;
	logic [lsw_pkg::MS_W-1:0]      min_s4, min_s5, sec_s5;

	logic [PH_W-1:0]               prod_h;
	logic [lsw_pkg::SEC_W-1:0]     hour_secs, rem_full;
	logic [PM_W-1:0]               prod_m;
	logic [lsw_pkg::REM_W-1:0]     min_secs, sec_left;

	// reciprocal multiply, then multiply back and subtract
	assign prod_h    = {{lsw_pkg::RH_W{1'b0}}, sec_s1[lsw_pkg::SEC_W-1:lsw_pkg::HSHIFT_IN]}
		* {{HX_W{1'b0}}, lsw_pkg::RECIP_HOUR};
	assign hour_secs = {{(lsw_pkg::SEC_W - lsw_pkg::HOURS_W){1'b0}}, hours_s2}
		* lsw_pkg::SEC_PER_HOUR;
	assign rem_full  = sec_s2 - hour_secs;
	assign prod_m    = {{lsw_pkg::RM_W{1'b0}}, rem_s3[lsw_pkg::REM_W-1:lsw_pkg::MSHIFT_IN]}
		* {{MX_W{1'b0}}, lsw_pkg::RECIP_MIN};
	assign min_secs  = {{(lsw_pkg::REM_W - lsw_pkg::MS_W){1'b0}}, min_s4}
		* lsw_pkg::SEC_PER_MIN;
	assign sec_left  = rem_s4 - min_secs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= load;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sec_s1 <= dividend;
		end
		if (vld_s1) begin
			sec_s2   <= sec_s1;
			hours_s2 <= prod_h[lsw_pkg::RH_SHIFT +: lsw_pkg::HOURS_W];
		end
		if (vld_s2) begin
			hours_s3 <= hours_s2;
			rem_s3   <= rem_full[lsw_pkg::REM_W-1:0];
		end
		if (vld_s3) begin
			hours_s4 <= hours_s3;
			rem_s4   <= rem_s3;
			min_s4   <= prod_m[lsw_pkg::RM_SHIFT +: lsw_pkg::MS_W];
		end
		if (vld_s4) begin
			hours_s5 <= hours_s4;
			min_s5   <= min_s4;
			sec_s5   <= sec_left[lsw_pkg::MS_W-1:0];
		end
	end

	assign hours   = hours_s5;
	assign minutes = min_s5;
	assign secs    = sec_s5;
	assign last    = vld_s5;

endmodule

// ===== design/lsw_ctrl.sv =====
module lsw_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  lsw_pkg::stat_t stat,
	output lsw_pkg::cmd_t  cmd
);

	lsw_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lsw_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			lsw_pkg::ST_IDLE: begin
				if (in_valid) state_d = lsw_pkg::ST_EXEC;
			end
			lsw_pkg::ST_EXEC:   state_d = lsw_pkg::ST_RD_A;
			lsw_pkg::ST_RD_A:   state_d = lsw_pkg::ST_RD_B;
			lsw_pkg::ST_RD_B:   state_d = lsw_pkg::ST_FORM;
			lsw_pkg::ST_FORM:   state_d = lsw_pkg::ST_CONV;
			lsw_pkg::ST_CONV: begin
				if (stat.div_last) state_d = lsw_pkg::ST_DONE;
			end
			lsw_pkg::ST_DONE: begin
				if (stat.out_free) state_d = lsw_pkg::ST_IDLE;
			end
			default:            state_d = lsw_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			lsw_pkg::ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
			end
			lsw_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
				cmd.rd   = 1'b1;
			end
			lsw_pkg::ST_RD_A: begin
				cmd.cap_a     = 1'b1;
				cmd.rd        = 1'b1;
				cmd.rd_second = 1'b1;
			end
			lsw_pkg::ST_RD_B:   cmd.cap_b    = 1'b1;
			lsw_pkg::ST_FORM:   cmd.form     = 1'b1;
			lsw_pkg::ST_DONE:   cmd.out_load = stat.out_free;
			default:            cmd          = '0;
		endcase
	end

endmodule

// ===== design/lsw_dpath.sv =====
module lsw_dpath #(
	parameter int SPLIT_SLOTS = lsw_pkg::SPLIT_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lsw_pkg::cmd_t                 cmd,
	output lsw_pkg::stat_t                stat,
	input  logic [2:0]                    req_type,
	input  logic [lsw_pkg::IDX_W-1:0]     first_index,
	input  logic [lsw_pkg::IDX_W-1:0]     second_index,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [lsw_pkg::HOURS_W-1:0]   hours,
	output logic [lsw_pkg::MS_W-1:0]      minutes,
	output logic [lsw_pkg::MS_W-1:0]      seconds_part,
	output logic [lsw_pkg::CS_W-1:0]      centis,
	output logic [lsw_pkg::LAP_W-1:0]     lap_count,
	output logic                          error_flag
);

	localparam int AW    = $clog2(SPLIT_SLOTS);
	localparam int NS_W  = $clog2(SPLIT_SLOTS + 1);
	localparam int ENT_W = lsw_pkg::SEC_W + lsw_pkg::CS_W;
	localparam int CMP_W = 9;

	lsw_pkg::req_t                 req_q;
	logic [lsw_pkg::IDX_W-1:0]     ia_q, ib_q;
	logic                          running_q;
	logic [lsw_pkg::CS_W-1:0]      centi_q;
	logic [lsw_pkg::SEC_W-1:0]     sec_q;
	logic [NS_W-1:0]               next_slot_q;
	logic [SPLIT_SLOTS-1:0]        valid_q;
	logic [ENT_W-1:0]              mem [SPLIT_SLOTS];
	logic [ENT_W-1:0]              rd_q;
	logic                          rd_ok_q;
	logic [lsw_pkg::SEC_W-1:0]     a_sec_q, b_sec_q;
	logic [lsw_pkg::CS_W-1:0]      a_cs_q, b_cs_q;
	logic [lsw_pkg::CS_W-1:0]      cs_q;
	logic                          err_q;
	logic                          out_valid_q;
	logic [lsw_pkg::HOURS_W-1:0]   hours_out_q;
	logic [lsw_pkg::MS_W-1:0]      min_out_q, sec_out_q;
	logic [lsw_pkg::CS_W-1:0]      cs_out_q;
	logic [lsw_pkg::LAP_W-1:0]     lap_out_q;
	logic                          err_out_q;

	logic                          full;
	logic                          save_wr;
	logic [lsw_pkg::IDX_W-1:0]     rd_idx;
	logic [AW-1:0]                 rd_addr, wr_addr;
	logic                          rd_in_range;
	logic [ENT_W-1:0]              rd_masked;

	logic                          a_lt_b, borrow;
	logic [lsw_pkg::SEC_W-1:0]     big_sec, small_sec, d_sec, src_sec;
	logic [lsw_pkg::CS_W-1:0]      big_cs, small_cs, d_cs, src_cs;
	logic                          src_err;

	logic [lsw_pkg::HOURS_W-1:0]   div_hours;
	logic [lsw_pkg::MS_W-1:0]      div_min, div_sec;
	logic                          div_last;

	assign full    = !(NS_W'(SPLIT_SLOTS) > next_slot_q);
	assign save_wr = cmd.exec && (req_q == lsw_pkg::REQ_SAVE) && !full;
	assign wr_addr = AW'(next_slot_q);

	assign rd_idx      = cmd.rd_second ? ib_q : ia_q;
	assign rd_addr     = AW'(rd_idx);
	assign rd_in_range = CMP_W'(rd_idx) < CMP_W'(SPLIT_SLOTS);
	assign rd_masked   = rd_ok_q ? rd_q : '0;

	// request latch and stopwatch state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q   <= 1'b0;
			centi_q     <= '0;
			sec_q       <= '0;
			next_slot_q <= NS_W'(1);
			valid_q     <= '0;
		end else if (cmd.exec) begin
			case (req_q)
				lsw_pkg::REQ_TICK: begin
					if (running_q) begin
						if (centi_q == lsw_pkg::CENTI_MAX) begin
							centi_q <= '0;
							sec_q   <= sec_q + 1'b1;
						end else begin
							centi_q <= centi_q + 1'b1;
						end
					end
				end
				lsw_pkg::REQ_START: running_q <= 1'b1;
				lsw_pkg::REQ_STOP:  running_q <= 1'b0;
				lsw_pkg::REQ_CLEAR: begin
					centi_q     <= '0;
					sec_q       <= '0;
					next_slot_q <= NS_W'(1);
					valid_q     <= '0;
				end
				lsw_pkg::REQ_SAVE: begin
					if (!full) begin
						valid_q[wr_addr] <= 1'b1;
						next_slot_q      <= next_slot_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q <= lsw_pkg::req_t'(req_type);
			ia_q  <= first_index;
			ib_q  <= second_index;
		end
	end

	// split memory, registered read
	always_ff @(posedge clk) begin
		if (save_wr) begin
			mem[wr_addr] <= {sec_q, centi_q};
		end
		if (cmd.rd) begin
			rd_q    <= mem[rd_addr];
			rd_ok_q <= rd_in_range && valid_q[rd_addr];
		end
	end

	// difference with centisecond borrow
	always_comb begin
		a_lt_b    = (a_sec_q < b_sec_q) || ((a_sec_q == b_sec_q) && (a_cs_q < b_cs_q));
		big_sec   = a_lt_b ? b_sec_q : a_sec_q;
		big_cs    = a_lt_b ? b_cs_q  : a_cs_q;
		small_sec = a_lt_b ? a_sec_q : b_sec_q;
		small_cs  = a_lt_b ? a_cs_q  : b_cs_q;
		borrow    = big_cs < small_cs;
		d_cs      = borrow
			? lsw_pkg::CS_W'({1'b0, big_cs} + 8'(lsw_pkg::CENTI_PER_SEC) - {1'b0, small_cs})
			: lsw_pkg::CS_W'(big_cs - small_cs);
		d_sec     = big_sec - small_sec - lsw_pkg::SEC_W'(borrow);

		case (req_q)
			lsw_pkg::REQ_READ: begin
				src_sec = a_sec_q;
				src_cs  = a_cs_q;
				src_err = 1'b0;
			end
			lsw_pkg::REQ_DIFF: begin
				src_sec = d_sec;
				src_cs  = d_cs;
				src_err = a_lt_b;
			end
			default: begin
				src_sec = sec_q;
				src_cs  = centi_q;
				src_err = err_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			err_q <= (req_q == lsw_pkg::REQ_SAVE) && full;
		end else if (cmd.form) begin
			err_q <= src_err;
		end
		if (cmd.cap_a) begin
			a_sec_q <= rd_masked[ENT_W-1:lsw_pkg::CS_W];
			a_cs_q  <= rd_masked[lsw_pkg::CS_W-1:0];
		end
		if (cmd.cap_b) begin
			b_sec_q <= rd_masked[ENT_W-1:lsw_pkg::CS_W];
			b_cs_q  <= rd_masked[lsw_pkg::CS_W-1:0];
		end
		if (cmd.form) begin
			cs_q <= src_cs;
		end
	end

	// seconds to hours, minutes and seconds
	lsw_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (cmd.form),
		.dividend (src_sec),
		.hours    (div_hours),
		.minutes  (div_min),
		.secs     (div_sec),
		.last     (div_last)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			hours_out_q <= div_hours;
			min_out_q   <= div_min;
			sec_out_q   <= div_sec;
			cs_out_q    <= cs_q;
			lap_out_q   <= lsw_pkg::LAP_W'(next_slot_q);
			err_out_q   <= err_q;
		end
	end

	assign stat.div_last = div_last;
	assign stat.out_free = !out_valid_q || !out_stall;

	assign out_valid    = out_valid_q;
	assign hours        = hours_out_q;
	assign minutes      = min_out_q;
	assign seconds_part = sec_out_q;
	assign centis       = cs_out_q;
	assign lap_count    = lap_out_q;
	assign error_flag   = err_out_q;

endmodule

// ===== design/lap_stopwatch.sv =====
// channel  handshake             payload
// in       in_valid / in_stall   req_type, first_index, second_index
// out      out_valid / out_stall hours, minutes, seconds_part, centis, lap_count, error_flag
//
// Every request gives one result; requests are stalled until that result is
// loaded, and the next request can be taken in the same cycle it turns valid.
// A request passes through execute, two split reads, forming and the five-stage time converter.
// arst_n clears the time, the split valid bits and the controller at once.
// A stalled result holds the output register; a request may be taken meanwhile,
// and waits at its end until the register is free.
module lap_stopwatch #(
	parameter int SPLIT_SLOTS = lsw_pkg::SPLIT_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [2:0]                    req_type,
	input  logic [lsw_pkg::IDX_W-1:0]     first_index,
	input  logic [lsw_pkg::IDX_W-1:0]     second_index,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [lsw_pkg::HOURS_W-1:0]   hours,
	output logic [lsw_pkg::MS_W-1:0]      minutes,
	output logic [lsw_pkg::MS_W-1:0]      seconds_part,
	output logic [lsw_pkg::CS_W-1:0]      centis,
	output logic [lsw_pkg::LAP_W-1:0]     lap_count,
	output logic                          error_flag
);

	lsw_pkg::cmd_t  cmd;
	lsw_pkg::stat_t stat;

	lsw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	lsw_dpath #(
		.SPLIT_SLOTS (SPLIT_SLOTS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.req_type     (req_type),
		.first_index  (first_index),
		.second_index (second_index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.hours        (hours),
		.minutes      (minutes),
		.seconds_part (seconds_part),
		.centis       (centis),
		.lap_count    (lap_count),
		.error_flag   (error_flag)
	);

endmodule
